### rtl/rtsm_pkg.sv
package rtsm_pkg;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    // Sequencer phases, one-hot.
    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_PRE    = 11'b000_0000_0010,
        PH_EN     = 11'b000_0000_0100,
        PH_CMD_HI = 11'b000_0000_1000,
        PH_CMD_LO = 11'b000_0001_0000,
        PH_WR_HI  = 11'b000_0010_0000,
        PH_WR_LO  = 11'b000_0100_0000,
        PH_RD_REL = 11'b000_1000_0000,
        PH_RD_HI  = 11'b001_0000_0000,
        PH_RD_LO  = 11'b010_0000_0000,
        PH_RD_END = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic       start_req;
        logic       operation;
        logic [7:0] command;
        logic [7:0] write_data;
        logic       io_in;
    } t_request;

    typedef struct packed {
        logic       enable_pin;
        logic       clock_pin;
        logic       data_out;
        logic       data_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_result;

endpackage

### rtl/rtsm_in_if.sv
interface rtsm_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic       operation;
    logic [7:0] command;
    logic [7:0] write_data;
    logic       io_in;

    modport source (
        output valid, start_req, operation, command, write_data, io_in,
        input  ready
    );
    modport sink (
        input  valid, start_req, operation, command, write_data, io_in,
        output ready
    );
endinterface

### rtl/rtsm_out_if.sv
interface rtsm_out_if;
    logic       valid;
    logic       ready;
    logic       enable_pin;
    logic       clock_pin;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;

    modport source (
        output valid, enable_pin, clock_pin, data_out, data_drive, busy_res, done_res,
               read_data,
        input  ready
    );
    modport sink (
        input  valid, enable_pin, clock_pin, data_out, data_drive, busy_res, done_res,
               read_data,
        output ready
    );
endinterface

### rtl/rtsm_seq.sv
// Transaction sequencer: advances by one tick for every accepted input transfer.
module rtsm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_half_period,
    input  rtsm_pkg::t_request i_req,
    output rtsm_pkg::t_result  o_result
);

    rtsm_pkg::t_phase r_phase, n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_tick_count, n_tick_count;
    logic [7:0] r_out_shift, n_out_shift;
    logic [7:0] r_pending, n_pending;
    logic [7:0] r_in_shift, n_in_shift;
    logic       r_is_read, n_is_read;
    logic [7:0] r_last_read, n_last_read;
    logic       r_en, n_en;
    logic       r_clk_pin, n_clk_pin;
    logic       r_dout, n_dout;
    logic       r_drv, n_drv;

    logic [7:0] half;
    logic       leave;
    logic       done;
    logic [3:0] bit_inc;
    logic [7:0] shifted;
    logic [7:0] sampled;

    assign half    = (i_half_period == 8'd0) ? 8'd1 : i_half_period;
    assign leave   = r_tick_count >= half;
    assign bit_inc = r_bit_count + 4'd1;
    assign shifted = {1'b0, r_out_shift[7:1]};
    assign sampled = {i_req.io_in, r_in_shift[7:1]};

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_tick_count = leave ? r_tick_count : r_tick_count + 8'd1;
        n_out_shift  = r_out_shift;
        n_pending    = r_pending;
        n_in_shift   = r_in_shift;
        n_is_read    = r_is_read;
        n_last_read  = r_last_read;
        n_en         = r_en;
        n_clk_pin    = r_clk_pin;
        n_dout       = r_dout;
        n_drv        = r_drv;
        done         = 1'b0;

        unique case (r_phase)
            rtsm_pkg::PH_PRE: if (leave) begin
                n_en = 1'b1; n_clk_pin = 1'b0; n_dout = 1'b0; n_drv = 1'b0;
                n_phase = rtsm_pkg::PH_EN;
                n_tick_count = 8'd1;
            end
            rtsm_pkg::PH_EN: if (leave) begin
                n_bit_count = 4'd0;
                n_en = 1'b1; n_clk_pin = 1'b1; n_drv = 1'b1; n_dout = r_out_shift[0];
                n_phase = rtsm_pkg::PH_CMD_HI;
                n_tick_count = 8'd1;
            end
            rtsm_pkg::PH_CMD_HI: if (leave) begin
                n_clk_pin = 1'b0;
                n_phase = rtsm_pkg::PH_CMD_LO;
                n_tick_count = 8'd1;
            end
            rtsm_pkg::PH_WR_HI: if (leave) begin
                n_clk_pin = 1'b0;
                n_phase = rtsm_pkg::PH_WR_LO;
                n_tick_count = 8'd1;
            end
            rtsm_pkg::PH_RD_HI: if (leave) begin
                n_clk_pin = 1'b0;
                n_phase = rtsm_pkg::PH_RD_LO;
                n_tick_count = 8'd1;
            end
            rtsm_pkg::PH_CMD_LO: if (leave) begin
                n_tick_count = 8'd1;
                if (bit_inc < rtsm_pkg::BITS_PER_BYTE) begin
                    n_out_shift = shifted;
                    n_bit_count = bit_inc;
                    n_en = 1'b1; n_clk_pin = 1'b1; n_drv = 1'b1; n_dout = shifted[0];
                    n_phase = rtsm_pkg::PH_CMD_HI;
                end else if (r_is_read) begin
                    n_out_shift = shifted;
                    n_bit_count = 4'd0;
                    n_en = 1'b1; n_clk_pin = 1'b0; n_dout = 1'b0; n_drv = 1'b0;
                    n_phase = rtsm_pkg::PH_RD_REL;
                end else begin
                    // Command done on a write: load the data byte and drive its first bit.
                    n_out_shift = r_pending;
                    n_bit_count = 4'd0;
                    n_en = 1'b1; n_clk_pin = 1'b1; n_drv = 1'b1; n_dout = r_pending[0];
                    n_phase = rtsm_pkg::PH_WR_HI;
                end
            end
            rtsm_pkg::PH_WR_LO: if (leave) begin
                n_out_shift = shifted;
                n_bit_count = bit_inc;
                if (bit_inc < rtsm_pkg::BITS_PER_BYTE) begin
                    n_en = 1'b1; n_clk_pin = 1'b1; n_drv = 1'b1; n_dout = shifted[0];
                    n_phase = rtsm_pkg::PH_WR_HI;
                    n_tick_count = 8'd1;
                end else begin
                    n_en = 1'b0; n_clk_pin = 1'b0; n_dout = 1'b0; n_drv = 1'b0;
                    n_phase = rtsm_pkg::PH_IDLE;
                    n_tick_count = 8'd0;
                    done = 1'b1;
                end
            end
            rtsm_pkg::PH_RD_REL: if (leave) begin
                n_in_shift = sampled;
                n_en = 1'b1; n_clk_pin = 1'b1; n_dout = 1'b0; n_drv = 1'b0;
                n_phase = rtsm_pkg::PH_RD_HI;
                n_tick_count = 8'd1;
            end
            rtsm_pkg::PH_RD_LO: if (leave) begin
                n_bit_count = bit_inc;
                n_tick_count = 8'd1;
                if (bit_inc < rtsm_pkg::BITS_PER_BYTE) begin
                    n_in_shift = sampled;
                    n_phase = rtsm_pkg::PH_RD_HI;
                end else begin
                    n_phase = rtsm_pkg::PH_RD_END;
                end
                n_en = 1'b1; n_clk_pin = 1'b1; n_dout = 1'b0; n_drv = 1'b0;
            end
            rtsm_pkg::PH_RD_END: if (leave) begin
                // The clock is left high in idle after a read.
                n_en = 1'b0; n_clk_pin = 1'b1; n_dout = 1'b0; n_drv = 1'b0;
                n_last_read = r_in_shift;
                n_phase = rtsm_pkg::PH_IDLE;
                n_tick_count = 8'd0;
                done = 1'b1;
            end
            default: begin
                // Idle, and any code without meaning.
                n_phase      = rtsm_pkg::PH_IDLE;
                n_tick_count = r_tick_count;
                if (i_req.start_req) begin
                    n_is_read    = i_req.operation;
                    n_out_shift  = i_req.command;
                    n_pending    = i_req.write_data;
                    n_bit_count  = 4'd0;
                    n_en = 1'b0; n_clk_pin = 1'b0; n_dout = 1'b0; n_drv = 1'b0;
                    n_phase      = rtsm_pkg::PH_PRE;
                    n_tick_count = 8'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= rtsm_pkg::PH_IDLE;
            r_bit_count  <= 4'd0;
            r_tick_count <= 8'd0;
            r_out_shift  <= 8'd0;
            r_pending    <= 8'd0;
            r_in_shift   <= 8'd0;
            r_is_read    <= 1'b0;
            r_last_read  <= 8'd0;
            r_en         <= 1'b0;
            r_clk_pin    <= 1'b0;
            r_dout       <= 1'b0;
            r_drv        <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_tick_count <= n_tick_count;
            r_out_shift  <= n_out_shift;
            r_pending    <= n_pending;
            r_in_shift   <= n_in_shift;
            r_is_read    <= n_is_read;
            r_last_read  <= n_last_read;
            r_en         <= n_en;
            r_clk_pin    <= n_clk_pin;
            r_dout       <= n_dout;
            r_drv        <= n_drv;
        end
    end

    always_comb begin
        o_result.enable_pin = n_en;
        o_result.clock_pin  = n_clk_pin;
        o_result.data_out   = n_drv & n_dout;
        o_result.data_drive = n_drv;
        o_result.busy_res   = n_phase != rtsm_pkg::PH_IDLE;
        o_result.done_res   = done;
        o_result.read_data  = n_last_read;
    end

endmodule

### rtl/rtsm_out_stage.sv
// Result register with valid/ready; takes a new result whenever the slot
// is empty or is being emptied in the same cycle.
module rtsm_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rtsm_pkg::t_result  i_result,
    output logic              o_can_load,
    rtsm_out_if.source        o_res
);

    logic              r_valid, n_valid;
    rtsm_pkg::t_result r_result;

    assign o_can_load = !r_valid || o_res.ready;
    assign n_valid    = i_load || (r_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.enable_pin = r_result.enable_pin;
    assign o_res.clock_pin  = r_result.clock_pin;
    assign o_res.data_out   = r_result.data_out;
    assign o_res.data_drive = r_result.data_drive;
    assign o_res.busy_res   = r_result.busy_res;
    assign o_res.done_res   = r_result.done_res;
    assign o_res.read_data  = r_result.read_data;

endmodule

### rtl/three_wire_serial_master_top.sv
// The result of an accepted input transfer is captured in the result register at the edge that accepts it.
// Throughput: one input transfer per cycle while the result side takes every result;
// the result register frees in the same cycle it is read.
// Reset (synchronous, active low): sequencer idle, pins low and data released,
// last read byte zero, half period two ticks, result register empty.
module three_wire_serial_master_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    rtsm_in_if.sink    i_req,
    rtsm_out_if.source o_res
);

    // Half-period length in ticks. Zero is treated as one inside the sequencer.
    logic [7:0] r_half_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= rtsm_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_wdata;
        end
    end

    // Each accepted input transfer is one tick of the serial link. The sequencer
    // state advances at the same edge the tick is accepted, and the resulting pin
    // levels and status are captured in the result register.
    rtsm_pkg::t_request req;
    rtsm_pkg::t_result  result;
    logic               can_load;
    logic               step;

    assign req.start_req  = i_req.start_req;
    assign req.operation  = i_req.operation;
    assign req.command    = i_req.command;
    assign req.write_data = i_req.write_data;
    assign req.io_in      = i_req.io_in;

    assign i_req.ready = can_load;
    assign step        = i_req.valid && can_load;

    rtsm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_half_period (r_half_period),
        .i_req         (req),
        .o_result      (result)
    );

    rtsm_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (result),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

    // A completing tick always reports the link as no longer busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.done_res && o_res.busy_res))
        else $error("done reported while still busy");

    // The data pin carries a level only while the master drives it.
    a_dout_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (!o_res.data_out || o_res.data_drive))
        else $error("data level without drive");

    // The result register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    // An input transfer while the result side stalls is impossible.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_req.ready)
        else $error("input taken over a stalled result");

endmodule

### tb/pin_sequence_checker.sv
// Watches both channels and the configuration port, predicts the pin levels and
// status of every tick and compares them with what the block returns.
module pin_sequence_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    rtsm_in_if         i_req,
    rtsm_out_if        i_res,
    output int         o_mismatch_count,
    output int         o_pending_count
);

    logic [7:0]       half_period;
    rtsm_pkg::t_phase seq_phase;
    logic [3:0]       bit_idx;
    logic [7:0]       tick_idx;
    logic [7:0]       tx_shift;
    logic [7:0]       tx_pending;
    logic [7:0]       rx_shift;
    logic [7:0]       last_byte;
    logic             rd_mode;
    logic             pin_en;
    logic             pin_clk;
    logic             pin_dout;
    logic             pin_drv;

    rtsm_pkg::t_result expected_pins[$];
    int                mismatch_total = 0;

    task automatic set_pins(input logic en, input logic sclk, input logic dout,
                            input logic drv);
        pin_en   = en;
        pin_clk  = sclk;
        pin_dout = dout;
        pin_drv  = drv;
    endtask

    task automatic enter_phase(input rtsm_pkg::t_phase next);
        seq_phase = next;
        tick_idx  = 8'd1;
    endtask

    // Put the next outgoing bit on the line with the clock high.
    task automatic drive_next_bit();
        set_pins(1'b1, 1'b1, tx_shift[0], 1'b1);
    endtask

    task automatic clear_sequencer();
        half_period = rtsm_pkg::HALF_PERIOD_RESET;
        seq_phase   = rtsm_pkg::PH_IDLE;
        bit_idx     = '0;
        tick_idx    = '0;
        tx_shift    = '0;
        tx_pending  = '0;
        rx_shift    = '0;
        last_byte   = '0;
        rd_mode     = 1'b0;
        set_pins(1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic advance_sequencer(input rtsm_pkg::t_request rq,
                                     output rtsm_pkg::t_result rs);
        logic [7:0] h;
        logic       done;
        h    = (half_period == 8'd0) ? 8'd1 : half_period;
        done = 1'b0;
        if (seq_phase == rtsm_pkg::PH_IDLE) begin
            if (rq.start_req) begin
                rd_mode    = rq.operation;
                tx_shift   = rq.command;
                tx_pending = rq.write_data;
                bit_idx    = '0;
                set_pins(1'b0, 1'b0, 1'b0, 1'b0);
                enter_phase(rtsm_pkg::PH_PRE);
            end
        end else if (tick_idx < h) begin
            tick_idx = tick_idx + 8'd1;
        end else begin
            case (seq_phase)
                rtsm_pkg::PH_PRE: begin
                    set_pins(1'b1, 1'b0, 1'b0, 1'b0);
                    enter_phase(rtsm_pkg::PH_EN);
                end
                rtsm_pkg::PH_EN: begin
                    bit_idx = '0;
                    drive_next_bit();
                    enter_phase(rtsm_pkg::PH_CMD_HI);
                end
                rtsm_pkg::PH_CMD_HI: begin
                    pin_clk = 1'b0;
                    enter_phase(rtsm_pkg::PH_CMD_LO);
                end
                rtsm_pkg::PH_WR_HI: begin
                    pin_clk = 1'b0;
                    enter_phase(rtsm_pkg::PH_WR_LO);
                end
                rtsm_pkg::PH_RD_HI: begin
                    pin_clk = 1'b0;
                    enter_phase(rtsm_pkg::PH_RD_LO);
                end
                rtsm_pkg::PH_CMD_LO: begin
                    tx_shift = tx_shift >> 1;
                    bit_idx  = bit_idx + 4'd1;
                    if (bit_idx < rtsm_pkg::BITS_PER_BYTE) begin
                        drive_next_bit();
                        enter_phase(rtsm_pkg::PH_CMD_HI);
                    end else if (rd_mode) begin
                        bit_idx = '0;
                        set_pins(1'b1, 1'b0, 1'b0, 1'b0);
                        enter_phase(rtsm_pkg::PH_RD_REL);
                    end else begin
                        bit_idx  = '0;
                        tx_shift = tx_pending;
                        drive_next_bit();
                        enter_phase(rtsm_pkg::PH_WR_HI);
                    end
                end
                rtsm_pkg::PH_WR_LO: begin
                    tx_shift = tx_shift >> 1;
                    bit_idx  = bit_idx + 4'd1;
                    if (bit_idx < rtsm_pkg::BITS_PER_BYTE) begin
                        drive_next_bit();
                        enter_phase(rtsm_pkg::PH_WR_HI);
                    end else begin
                        set_pins(1'b0, 1'b0, 1'b0, 1'b0);
                        seq_phase = rtsm_pkg::PH_IDLE;
                        tick_idx  = '0;
                        done      = 1'b1;
                    end
                end
                rtsm_pkg::PH_RD_REL: begin
                    rx_shift = {rq.io_in, rx_shift[7:1]};
                    set_pins(1'b1, 1'b1, 1'b0, 1'b0);
                    enter_phase(rtsm_pkg::PH_RD_HI);
                end
                rtsm_pkg::PH_RD_LO: begin
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx < rtsm_pkg::BITS_PER_BYTE) begin
                        rx_shift = {rq.io_in, rx_shift[7:1]};
                        enter_phase(rtsm_pkg::PH_RD_HI);
                    end else begin
                        enter_phase(rtsm_pkg::PH_RD_END);
                    end
                    set_pins(1'b1, 1'b1, 1'b0, 1'b0);
                end
                default: begin
                    // End of a read: the clock is left high in idle.
                    set_pins(1'b0, 1'b1, 1'b0, 1'b0);
                    last_byte = rx_shift;
                    seq_phase = rtsm_pkg::PH_IDLE;
                    tick_idx  = '0;
                    done      = 1'b1;
                end
            endcase
        end
        rs.enable_pin = pin_en;
        rs.clock_pin  = pin_clk;
        rs.data_out   = pin_drv & pin_dout;
        rs.data_drive = pin_drv;
        rs.busy_res   = (seq_phase != rtsm_pkg::PH_IDLE);
        rs.done_res   = done;
        rs.read_data  = last_byte;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        rtsm_pkg::t_request rq;
        rtsm_pkg::t_result  want;
        rtsm_pkg::t_result  fresh;
        if (!i_rst_n) begin
            clear_sequencer();
            expected_pins.delete();
        end else begin
            // Results leave before new requests enter, so a result taken at the same
            // edge as a request always belongs to an earlier request.
            if (i_res.valid && i_res.ready) begin
                if (expected_pins.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    mismatch_total++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("enable_pin", 8'(want.enable_pin), 8'(i_res.enable_pin));
                    check_field("clock_pin", 8'(want.clock_pin), 8'(i_res.clock_pin));
                    check_field("data_out", 8'(want.data_out), 8'(i_res.data_out));
                    check_field("data_drive", 8'(want.data_drive), 8'(i_res.data_drive));
                    check_field("busy_res", 8'(want.busy_res), 8'(i_res.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(i_res.done_res));
                    check_field("read_data", want.read_data, i_res.read_data);
                end
            end
            if (i_req.valid && i_req.ready) begin
                rq.start_req  = i_req.start_req;
                rq.operation  = i_req.operation;
                rq.command    = i_req.command;
                rq.write_data = i_req.write_data;
                rq.io_in      = i_req.io_in;
                advance_sequencer(rq, fresh);
                expected_pins.push_back(fresh);
            end
            if (i_cfg_we) begin
                half_period = i_cfg_wdata;
            end
        end
        o_pending_count  <= expected_pins.size();
        o_mismatch_count <= mismatch_total;
    end

endmodule

### tb/tb_three_wire_serial_master_top.sv
// Testbench top: makes the tick stream, drives the result side, owns the watchdog and
// prints the verdict. All prediction and comparison happens in the checker.
module tb_three_wire_serial_master_top;

    // Cycles without any transfer before the run is declared hung. The longest
    // legitimate quiet stretch is the deliberate receiver hold-off (HOLDOFF_CYCLES), so
    // this leaves ample margin.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 200;
    // A read, the longest transaction, lasts 36 half periods of 2 ticks at the reset
    // half period, so this much filler always lets a directed transaction run to its end.
    localparam int DIRECTED_FILL  = 76;
    localparam int START_PCT      = 40;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int holdoff_request    = 0;
    int mismatch_count;
    int pending_count;

    rtsm_in_if  req_if ();
    rtsm_out_if res_if ();

    three_wire_serial_master_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    pin_sequence_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_req            (req_if),
        .i_res            (res_if),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // One tick of the serial link with random content. The data pin level is always
    // random so that reads assemble arbitrary bytes.
    function automatic rtsm_pkg::t_request random_tick(input int start_pct);
        rtsm_pkg::t_request r;
        r.start_req  = ($urandom_range(99) < start_pct);
        r.operation  = 1'($urandom_range(1));
        r.command    = 8'($urandom_range(255));
        r.write_data = 8'($urandom_range(255));
        r.io_in      = 1'($urandom_range(1));
        return r;
    endfunction

    // Offers one tick and returns in the time step of the edge that accepted it.
    // Random idle cycles come first, so valid is assigned only once per step.
    task automatic offer_tick(input rtsm_pkg::t_request r);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.start_req  <= r.start_req;
        req_if.operation  <= r.operation;
        req_if.command    <= r.command;
        req_if.write_data <= r.write_data;
        req_if.io_in      <= r.io_in;
        do begin
            @(posedge clk);
        end while (!req_if.ready);
    endtask

    // Stops offering, waits for every outstanding result, then lets the block settle
    // before the half period register is rewritten.
    task automatic drain_and_configure(input logic [7:0] half_period);
        req_if.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending_count != 0);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= half_period;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A directed transaction: the start tick, then filler ticks that let it finish.
    // One filler tick carries a start request of the other kind, which the block must
    // ignore because it is busy. An io_mode of 0 or 1 holds the data pin at that level;
    // any other value leaves it random.
    task automatic directed_transaction(input logic op, input logic [7:0] cmd,
                                        input logic [7:0] data, input int io_mode);
        rtsm_pkg::t_request r;
        r.start_req  = 1'b1;
        r.operation  = op;
        r.command    = cmd;
        r.write_data = data;
        r.io_in      = (io_mode == 1);
        offer_tick(r);
        for (int i = 0; i < DIRECTED_FILL; i++) begin
            r = random_tick(0);
            if (i == 4) begin
                r.start_req = 1'b1;
                r.operation = ~op;
            end
            if (io_mode == 0 || io_mode == 1) begin
                r.io_in = (io_mode == 1);
            end
            offer_tick(r);
        end
    endtask

    task automatic random_phase(input logic [7:0] half_period, input int idle_pct,
                                input int stall_pct, input int items, input int holdoff);
        drain_and_configure(half_period);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        if (holdoff > 0) begin
            holdoff_request = holdoff;
        end
        repeat (items) offer_tick(random_tick(START_PCT));
    endtask

    // Result side. A hold-off request from the stimulus is taken over here and counted
    // down in this process, keeping ready low while the sender keeps offering ticks, so
    // the result register fills and the block stalls its input.
    initial begin : result_taker
        int hold;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holdoff_request > 0) begin
                hold            = holdoff_request;
                holdoff_request = 0;
            end
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                hold--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Ends the run if neither channel moves a transfer for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL three_wire_serial_master_top");
        $finish;
    end

    initial begin : stimulus
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= 8'd0;
        req_if.valid      <= 1'b0;
        req_if.start_req  <= 1'b0;
        req_if.operation  <= 1'b0;
        req_if.command    <= 8'd0;
        req_if.write_data <= 8'd0;
        req_if.io_in      <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset half period with no idling: all-zero and all-one
        // command and data bytes, reads that assemble all ones and all zeros, and a
        // mixed pattern. Every one also tries a start while busy.
        directed_transaction(1'b0, 8'h00, 8'hff, 2);
        directed_transaction(1'b1, 8'hff, 8'h00, 1);
        directed_transaction(1'b1, 8'h81, 8'h7e, 0);
        directed_transaction(1'b0, 8'ha5, 8'h5a, 2);

        // Random part. The half period sweeps its minimum, zero (which behaves as one),
        // a few small values and finally the maximum, which only gets far enough to
        // exercise long half periods since a whole transaction would take thousands of
        // ticks. Every phase starts with the sender waiting for all results.
        random_phase(8'd1, 0, 0, 150, 0);
        random_phase(8'd0, 73, 0, 150, 0);
        random_phase(8'd3, 0, 73, 150, 0);
        random_phase(8'($urandom_range(3, 1)), 24, 24, 150, 0);
        random_phase(8'd2, 0, 0, 150, HOLDOFF_CYCLES);
        random_phase(8'd255, 24, 24, 200, 0);

        // All ticks are in: wait for the last results, then let the clock run on in case
        // the block produces anything unexpected.
        req_if.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending_count != 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("PASS three_wire_serial_master_top");
        end else begin
            $display("FAIL three_wire_serial_master_top");
        end
        $finish;
    end

endmodule

### three_wire_serial_master_top.f
rtl/rtsm_pkg.sv
rtl/rtsm_in_if.sv
rtl/rtsm_out_if.sv
rtl/rtsm_seq.sv
rtl/rtsm_out_stage.sv
rtl/three_wire_serial_master_top.sv
tb/pin_sequence_checker.sv
tb/tb_three_wire_serial_master_top.sv
